@@ design/clseq_pkg.sv @@
// clseq_pkg: shared types, codes and the control-word program of the lcd sequencer
package clseq_pkg;

  // request kinds
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_POWER_ON   = 3'd0;
  localparam logic [2:0] CFG_SETUP      = 3'd1;
  localparam logic [2:0] CFG_ENABLE_HI  = 3'd2;
  localparam logic [2:0] CFG_AFTER_EN   = 3'd3;
  localparam logic [2:0] CFG_CLEAR_WAIT = 3'd4;
  localparam logic [2:0] CFG_LINE2_BASE = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // fixed waits of the wake sequence, in microseconds
  localparam logic [15:0] WAKE_FIRST_US  = 16'd5000;
  localparam logic [15:0] WAKE_SECOND_US = 16'd150;
  localparam logic [15:0] INIT_END_US    = 16'd2000;

  // fixed command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

  // program layout
  localparam int ROM_DEPTH = 47;
  localparam int STEP_W    = $clog2(ROM_DEPTH);
  localparam logic [STEP_W-1:0] INIT_ENTRY      = STEP_W'(0);
  localparam logic [STEP_W-1:0] BYTE_ENTRY      = STEP_W'(40);

  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HIGH,
    NIB_LOW
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_POWER,
    HOLD_SETUP,
    HOLD_ENABLE,
    HOLD_AFTER,
    HOLD_CLEAR,
    HOLD_WAKE1,
    HOLD_WAKE2,
    HOLD_END
  } hold_sel_t;

  typedef enum logic [1:0] {
    CTL_NEXT,
    CTL_END,
    CTL_END_UNLESS_CLEAR
  } seq_ctl_t;

  typedef struct packed {
    nib_sel_t  nib_sel;
    logic [3:0] nib;
    logic      en;
    hold_sel_t hold_sel;
    seq_ctl_t  ctl;
  } ctrl_t;

  // a plain wait step with enable low
  function automatic ctrl_t wait_word(input logic [3:0] nib, input hold_sel_t hold,
                                      input seq_ctl_t ctl);
    ctrl_t w;
    w.nib_sel  = NIB_CONST;
    w.nib      = nib;
    w.en       = 1'b0;
    w.hold_sel = hold;
    w.ctl      = ctl;
    return w;
  endfunction

  // one of the three phases of a nibble: setup, enable high, enable low
  function automatic ctrl_t nib_word(input nib_sel_t sel, input logic [3:0] nib,
                                     input logic [1:0] ph);
    ctrl_t w;
    w.nib_sel = sel;
    w.nib     = nib;
    w.ctl     = CTL_NEXT;
    case (ph)
      2'd0: begin
        w.en       = 1'b0;
        w.hold_sel = HOLD_SETUP;
      end
      2'd1: begin
        w.en       = 1'b1;
        w.hold_sel = HOLD_ENABLE;
      end
      default: begin
        w.en       = 1'b0;
        w.hold_sel = HOLD_AFTER;
      end
    endcase
    return w;
  endfunction

  // control store: init program, then the shared byte routine and the clear wait
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] addr);
    ctrl_t w;
    case (addr)
      6'd0:  w = wait_word(4'h0, HOLD_POWER, CTL_NEXT);
      6'd1:  w = nib_word(NIB_CONST, 4'h3, 2'd0);
      6'd2:  w = nib_word(NIB_CONST, 4'h3, 2'd1);
      6'd3:  w = nib_word(NIB_CONST, 4'h3, 2'd2);
      6'd4:  w = wait_word(4'h3, HOLD_WAKE1, CTL_NEXT);
      6'd5:  w = nib_word(NIB_CONST, 4'h3, 2'd0);
      6'd6:  w = nib_word(NIB_CONST, 4'h3, 2'd1);
      6'd7:  w = nib_word(NIB_CONST, 4'h3, 2'd2);
      6'd8:  w = wait_word(4'h3, HOLD_WAKE2, CTL_NEXT);
      6'd9:  w = nib_word(NIB_CONST, 4'h3, 2'd0);
      6'd10: w = nib_word(NIB_CONST, 4'h3, 2'd1);
      6'd11: w = nib_word(NIB_CONST, 4'h3, 2'd2);
      6'd12: w = nib_word(NIB_CONST, 4'h2, 2'd0);
      6'd13: w = nib_word(NIB_CONST, 4'h2, 2'd1);
      6'd14: w = nib_word(NIB_CONST, 4'h2, 2'd2);
      // function set 0x28
      6'd15: w = nib_word(NIB_CONST, 4'h2, 2'd0);
      6'd16: w = nib_word(NIB_CONST, 4'h2, 2'd1);
      6'd17: w = nib_word(NIB_CONST, 4'h2, 2'd2);
      6'd18: w = nib_word(NIB_CONST, 4'h8, 2'd0);
      6'd19: w = nib_word(NIB_CONST, 4'h8, 2'd1);
      6'd20: w = nib_word(NIB_CONST, 4'h8, 2'd2);
      // display on 0x0c
      6'd21: w = nib_word(NIB_CONST, 4'h0, 2'd0);
      6'd22: w = nib_word(NIB_CONST, 4'h0, 2'd1);
      6'd23: w = nib_word(NIB_CONST, 4'h0, 2'd2);
      6'd24: w = nib_word(NIB_CONST, 4'hC, 2'd0);
      6'd25: w = nib_word(NIB_CONST, 4'hC, 2'd1);
      6'd26: w = nib_word(NIB_CONST, 4'hC, 2'd2);
      // entry mode 0x06
      6'd27: w = nib_word(NIB_CONST, 4'h0, 2'd0);
      6'd28: w = nib_word(NIB_CONST, 4'h0, 2'd1);
      6'd29: w = nib_word(NIB_CONST, 4'h0, 2'd2);
      6'd30: w = nib_word(NIB_CONST, 4'h6, 2'd0);
      6'd31: w = nib_word(NIB_CONST, 4'h6, 2'd1);
      6'd32: w = nib_word(NIB_CONST, 4'h6, 2'd2);
      // clear display 0x01
      6'd33: w = nib_word(NIB_CONST, 4'h0, 2'd0);
      6'd34: w = nib_word(NIB_CONST, 4'h0, 2'd1);
      6'd35: w = nib_word(NIB_CONST, 4'h0, 2'd2);
      6'd36: w = nib_word(NIB_CONST, 4'h1, 2'd0);
      6'd37: w = nib_word(NIB_CONST, 4'h1, 2'd1);
      6'd38: w = nib_word(NIB_CONST, 4'h1, 2'd2);
      6'd39: w = wait_word(4'h1, HOLD_END, CTL_END);
      // shared byte routine from the byte register
      6'd40: w = nib_word(NIB_HIGH, 4'h0, 2'd0);
      6'd41: w = nib_word(NIB_HIGH, 4'h0, 2'd1);
      6'd42: w = nib_word(NIB_HIGH, 4'h0, 2'd2);
      6'd43: w = nib_word(NIB_LOW, 4'h0, 2'd0);
      6'd44: w = nib_word(NIB_LOW, 4'h0, 2'd1);
      6'd45: begin
        w     = nib_word(NIB_LOW, 4'h0, 2'd2);
        w.ctl = CTL_END_UNLESS_CLEAR;
      end
      6'd46: w = wait_word(4'h1, HOLD_CLEAR, CTL_END);
      default: w = wait_word(4'h0, HOLD_END, CTL_END);
    endcase
    return w;
  endfunction

endpackage

@@ design/char_lcd_4bit_sequencer_core.sv @@
// char_lcd_4bit_sequencer_core: microcoded 4-bit character lcd pin sequencer
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  request  | start / busy       | in_req_type, in_value, in_row_select, in_column
//  result   | out_valid (strobe) | out_rs_pin, out_data_pins, out_enable_pin,
//           |                    | out_hold_us, out_last
//  config   | cfg_we             | cfg_index, cfg_wdata
//
//  one result word per clock: one control-store step per cycle, and busy stays high
//  until the last step of a request (results: init 40, clear 7, others 6).
//  each result sits on the output registers for one cycle, in the cycle after its step.
//  a new request is taken in the cycle the last word of the previous run is shown.
//  unknown request kinds are taken and produce no words.
//  synchronous active-low reset returns the control and config registers to their defaults, idle.
module char_lcd_4bit_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_req_type,
  input  logic [7:0]                      in_value,
  input  logic                            in_row_select,
  input  logic [6:0]                      in_column,
  output logic                            out_valid,
  output logic                            out_rs_pin,
  output logic [3:0]                      out_data_pins,
  output logic                            out_enable_pin,
  output logic [15:0]                     out_hold_us,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [clseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clseq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] power_on_r;
  logic [7:0]  setup_r;
  logic [7:0]  enable_hi_r;
  logic [9:0]  after_en_r;
  logic [15:0] clear_wait_r;
  logic [6:0]  line2_base_r;

  logic                          busy_r, busy_nxt;
  logic [clseq_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic                          rs_r, rs_nxt;
  logic                          clear_r, clear_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_rs_r, out_rs_nxt;
  logic [3:0]  out_nib_r, out_nib_nxt;
  logic        out_en_r, out_en_nxt;
  logic [15:0] out_hold_r, out_hold_nxt;
  logic        out_last_r, out_last_nxt;

  clseq_pkg::ctrl_t cw;
  logic        accept;
  logic        known_kind;
  logic [7:0]  addr_sum;
  logic        step_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r   <= 16'd20000;
      setup_r      <= 8'd1;
      enable_hi_r  <= 8'd2;
      after_en_r   <= 10'd200;
      clear_wait_r <= 16'd5000;
      line2_base_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        clseq_pkg::CFG_POWER_ON:   power_on_r   <= cfg_wdata;
        clseq_pkg::CFG_SETUP:      setup_r      <= cfg_wdata[7:0];
        clseq_pkg::CFG_ENABLE_HI:  enable_hi_r  <= cfg_wdata[7:0];
        clseq_pkg::CFG_AFTER_EN:   after_en_r   <= cfg_wdata[9:0];
        clseq_pkg::CFG_CLEAR_WAIT: clear_wait_r <= cfg_wdata;
        clseq_pkg::CFG_LINE2_BASE: line2_base_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // request decode
  assign accept     = start && !busy_r;
  assign known_kind = (in_req_type inside {[clseq_pkg::REQ_INIT : clseq_pkg::REQ_CLEAR]});
  assign addr_sum   = {1'b0, (in_row_select ? line2_base_r : 7'd0)} + {1'b0, in_column};

  // control store read
  assign cw = clseq_pkg::rom_word(step_r);

  // sequencer and datapath next values
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    byte_nxt      = byte_r;
    rs_nxt        = rs_r;
    clear_nxt     = clear_r;
    out_valid_nxt = 1'b0;
    out_rs_nxt    = rs_r;
    out_en_nxt    = cw.en;
    out_last_nxt  = 1'b0;
    step_done     = 1'b0;

    case (cw.nib_sel)
      clseq_pkg::NIB_HIGH: out_nib_nxt = byte_r[7:4];
      clseq_pkg::NIB_LOW:  out_nib_nxt = byte_r[3:0];
      default:             out_nib_nxt = cw.nib;
    endcase

    case (cw.hold_sel)
      clseq_pkg::HOLD_POWER:  out_hold_nxt = power_on_r;
      clseq_pkg::HOLD_SETUP:  out_hold_nxt = {8'd0, setup_r};
      clseq_pkg::HOLD_ENABLE: out_hold_nxt = {8'd0, enable_hi_r};
      clseq_pkg::HOLD_AFTER:  out_hold_nxt = {6'd0, after_en_r};
      clseq_pkg::HOLD_CLEAR:  out_hold_nxt = clear_wait_r;
      clseq_pkg::HOLD_WAKE1:  out_hold_nxt = clseq_pkg::WAKE_FIRST_US;
      clseq_pkg::HOLD_WAKE2:  out_hold_nxt = clseq_pkg::WAKE_SECOND_US;
      default:                out_hold_nxt = clseq_pkg::INIT_END_US;
    endcase

    case (cw.ctl)
      clseq_pkg::CTL_END:              step_done = 1'b1;
      clseq_pkg::CTL_END_UNLESS_CLEAR: step_done = !clear_r;
      default:                         step_done = 1'b0;
    endcase

    if (busy_r) begin
      // one step per cycle, result word registered
      out_valid_nxt = 1'b1;
      out_last_nxt  = step_done;
      if (step_done) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end else if (accept && known_kind) begin
      // load byte register, rs level, clear flag and entry point
      busy_nxt  = 1'b1;
      rs_nxt    = (in_req_type == clseq_pkg::REQ_DATA);
      clear_nxt = (in_req_type == clseq_pkg::REQ_CLEAR);
      step_nxt  = (in_req_type == clseq_pkg::REQ_INIT) ? clseq_pkg::INIT_ENTRY
                                                        : clseq_pkg::BYTE_ENTRY;
      case (in_req_type)
        clseq_pkg::REQ_CURSOR: byte_nxt = clseq_pkg::CMD_SET_DDRAM | {1'b0, addr_sum[6:0]};
        clseq_pkg::REQ_CLEAR:  byte_nxt = clseq_pkg::CMD_CLEAR;
        default:               byte_nxt = in_value;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= clseq_pkg::INIT_ENTRY;
      out_valid_r <= 1'b0;
      rs_r        <= 1'b0;
      clear_r     <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      rs_r        <= rs_nxt;
      clear_r     <= clear_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_rs_r   <= out_rs_nxt;
    out_nib_r  <= out_nib_nxt;
    out_en_r   <= out_en_nxt;
    out_hold_r <= out_hold_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_rs_pin     = out_rs_r;
  assign out_data_pins  = out_nib_r;
  assign out_enable_pin = out_en_r;
  assign out_hold_us    = out_hold_r;
  assign out_last       = out_last_r && out_valid_r;

endmodule

@@ design/clseq_checker.sv @@
// clseq_checker: port-level assertions for the lcd sequencer, bound to the top level
module clseq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_req_type,
  input logic       out_valid,
  input logic       out_enable_pin,
  input logic       out_last
);

  // a result word only follows a busy cycle
  a_word_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a busy cycle before it");

  // a known request starts a run
  a_known_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type <= clseq_pkg::REQ_CLEAR)) |=> busy)
    else $error("known request did not start a run");

  // the run ends with a last word and nothing after it
  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_valid && out_last))
    else $error("run ended without a last word");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("word shown right after the last word");

  // a run never ends with enable high
  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !out_enable_pin)
    else $error("last word leaves enable high");

endmodule

bind char_lcd_4bit_sequencer_core clseq_checker u_clseq_checker (.*);
